/* rtl/xpf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package xpf_pkg;

  // Field widths
  localparam int WORD_W = 32;
  localparam int LEN_W  = 7;
  localparam int BYTE_W = 8;
  localparam int MODE_W = 3;

  // Longest fill; longer requests saturate here
  localparam logic [LEN_W-1:0] MAX_FILL = 7'd64;

  // Generator constants
  localparam logic [WORD_W-1:0] SEED_DEFAULT = 32'h1234_5678;
  localparam logic [WORD_W-1:0] GEN_ZERO_SUB = 32'hA5A5_A5A5;
  localparam int SHIFT_A = 13;
  localparam int SHIFT_B = 17;
  localparam int SHIFT_C = 5;

  // Opcodes
  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_FILL = 1'b1;

  // Fill pattern modes
  localparam logic [MODE_W-1:0] MODE_ZERO  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ONES  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INDEX = 3'd2;
  localparam logic [MODE_W-1:0] MODE_COUNT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PICK  = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAW,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_item;  // capture opcode and length
    logic draw;       // step generator once for the transaction
    logic emit;       // produce one fill byte
  } xpf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic opcode;
    logic len_zero;
    logic last_byte;
    logic out_free;
  } xpf_status_t;

  // One xorshift step, zero result replaced
  function automatic logic [WORD_W-1:0] xs_step(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] t;
    t = x ^ (x << SHIFT_A);
    t = t ^ (t >> SHIFT_B);
    t = t ^ (t << SHIFT_C);
    return (t == '0) ? GEN_ZERO_SUB : t;
  endfunction

  // Byte table for the pick mode
  function automatic logic [BYTE_W-1:0] pick_byte(input logic [3:0] sel);
    logic [BYTE_W-1:0] b;
    case (sel)
      4'd0:    b = 8'h00;
      4'd1:    b = 8'h01;
      4'd2:    b = 8'h02;
      4'd3:    b = 8'h03;
      4'd4:    b = 8'h07;
      4'd5:    b = 8'h08;
      4'd6:    b = 8'h0f;
      4'd7:    b = 8'h10;
      4'd8:    b = 8'h1f;
      4'd9:    b = 8'h20;
      4'd10:   b = 8'h3f;
      4'd11:   b = 8'h40;
      4'd12:   b = 8'h7f;
      4'd13:   b = 8'h80;
      4'd14:   b = 8'hfe;
      default: b = 8'hff;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* rtl/xpf_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module xpf_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire xpf_pkg::xpf_cmd_t           cmd,
  output xpf_pkg::xpf_status_t             status,
  input  wire logic                        opcode,
  input  wire logic [xpf_pkg::LEN_W-1:0]   fill_length,
  input  wire logic                        cfg_we,
  input  wire logic [xpf_pkg::WORD_W-1:0]  cfg_wdata,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [xpf_pkg::WORD_W-1:0]       value,
  output logic                             last
);
  import xpf_pkg::*;

  logic [WORD_W-1:0] gen;
  logic [WORD_W-1:0] gen_next;
  logic              op_q;
  logic [LEN_W-1:0]  len_q;
  logic [LEN_W-1:0]  len_sat;
  logic [MODE_W-1:0] mode_q;
  logic [LEN_W-1:0]  idx;
  logic [BYTE_W-1:0] fill_byte;
  logic              mode_draws;

  assign gen_next   = xs_step(gen);
  assign len_sat    = (fill_length > MAX_FILL) ? MAX_FILL : fill_length;
  assign mode_draws = mode_q[MODE_W-1];

  // Pattern byte for the current index
  always_comb begin
    case (mode_q)
      MODE_ZERO:  fill_byte = 8'h00;
      MODE_ONES:  fill_byte = 8'hff;
      MODE_INDEX: fill_byte = {1'b0, idx};
      MODE_COUNT: fill_byte = {1'b0, len_q - idx};
      MODE_PICK:  fill_byte = pick_byte(gen_next[3:0]);
      default:    fill_byte = gen_next[BYTE_W-1:0];
    endcase
  end

  assign status.opcode    = op_q;
  assign status.len_zero  = (len_q == '0);
  assign status.last_byte = (idx + 7'd1 == len_q);
  assign status.out_free  = !out_valid || out_ready;

  // Generator state; seed writes must come only when idle, which the block itself does not enforce
  always_ff @(posedge clk) begin
    if (rst) begin
      gen <= SEED_DEFAULT;
    end else if (cfg_we) begin
      gen <= (cfg_wdata == '0) ? SEED_DEFAULT : cfg_wdata;
    end else if (cmd.draw || (cmd.emit && mode_draws)) begin
      gen <= gen_next;
    end
  end

  // Transaction capture, mode and byte index
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q  <= opcode;
      len_q <= len_sat;
    end
    if (cmd.draw && op_q == OP_FILL) begin
      mode_q <= gen_next[MODE_W-1:0];
      idx    <= '0;
    end else if (cmd.emit) begin
      idx <= idx + 7'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || (cmd.draw && op_q == OP_DRAW)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.draw && op_q == OP_DRAW) begin
      value <= gen_next;
      last  <= 1'b1;
    end else if (cmd.emit) begin
      value <= {{(WORD_W-BYTE_W){1'b0}}, fill_byte};
      last  <= status.last_byte;
    end
  end

endmodule

`default_nettype wire

/* rtl/xpf_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module xpf_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  output xpf_pkg::xpf_cmd_t          cmd,
  input  wire xpf_pkg::xpf_status_t  status
);
  import xpf_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    cmd.load_item = 1'b0;
    cmd.draw      = 1'b0;
    cmd.emit      = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_DRAW;
        end
      end
      ST_DRAW: begin
        if (status.opcode == OP_DRAW) begin
          // word goes straight to the output register
          if (status.out_free) begin
            cmd.draw   = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          // mode draw; empty fill ends here
          cmd.draw   = 1'b1;
          state_next = status.len_zero ? ST_IDLE : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.last_byte) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/xorshift_pattern_filler_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Xorshift pattern filler: a 32-bit xorshift generator (13/17/5) that either
// returns one random word per transaction (opcode 0) or a run of fill bytes
// (opcode 1, length saturated at 64, byte in value[7:0], last on the final
// byte). A draw is accepted, then its word goes to the result register once
// the output register is free; a fill is accepted, its mode is drawn, then one
// byte per cycle is given while the output register is free. One transaction
// is worked on at a time; a new one is accepted while the last result still
// waits in the output register. Writing cfg_wdata with cfg_we reloads the
// generator (zero loads 0x12345678); write only while the unit is idle.
module xorshift_pattern_filler_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        opcode,
  input  wire logic [xpf_pkg::LEN_W-1:0]   fill_length,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [xpf_pkg::WORD_W-1:0]       value,
  output logic                             last,
  input  wire logic                        cfg_we,
  input  wire logic [xpf_pkg::WORD_W-1:0]  cfg_wdata
);
  import xpf_pkg::*;

  xpf_cmd_t    cmd;
  xpf_status_t status;

  xpf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  xpf_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .opcode      (opcode),
    .fill_length (fill_length),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .value       (value),
    .last        (last)
  );

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import xpf_pkg::*;

  // Cycles with no transaction on any port before the run is abandoned
  localparam int STALL_LIMIT = 2000;
  // Settling time after the last result; a zero-length fill gives no result
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS = 44;
  localparam int PLAN_ROWS = 22;

  localparam logic [BYTE_W-1:0] PICK_LUT [16] = '{
    8'h00, 8'h01, 8'h02, 8'h03, 8'h07, 8'h08, 8'h0f, 8'h10,
    8'h1f, 8'h20, 8'h3f, 8'h40, 8'h7f, 8'h80, 8'hfe, 8'hff
  };

  typedef enum logic [1:0] {
    ROW_SEED,   // write the seed register, arg is the seed
    ROW_ITEM,   // transaction checked against the predictor
    ROW_TYPED   // transaction whose results are given in arg
  } row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic                op;
    logic [LEN_W-1:0]    len;
    logic [WORD_W-1:0]   arg;
  } plan_row_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              last;
  } fill_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              opcode = OP_DRAW;
  logic [LEN_W-1:0]  fill_length = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [WORD_W-1:0] value;
  logic              last;
  logic              cfg_we = 1'b0;
  logic [WORD_W-1:0] cfg_wdata = '0;

  // Predictor state
  logic [WORD_W-1:0] gen_word = SEED_DEFAULT;
  fill_result_t      owed_results [$];

  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  quiet_stretch = 1'b0;
  plan_row_t plan [PLAN_ROWS];

  xorshift_pattern_filler_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .fill_length (fill_length),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .value       (value),
    .last        (last),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // One generator step: shifts 13 left, 17 right, 5 left; zero is replaced
  function automatic logic [WORD_W-1:0] xorshift_next(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] t;
    t = x ^ {x[WORD_W-14:0], 13'b0};
    t = t ^ {17'b0, t[WORD_W-1:17]};
    t = t ^ {t[WORD_W-6:0], 5'b0};
    if (t == '0) begin
      t = GEN_ZERO_SUB;
    end
    return t;
  endfunction

  // Advance the predictor over one transaction; queue its results if asked
  task automatic forecast_run(input logic op, input logic [LEN_W-1:0] req_len,
                              input bit keep);
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] b;
    int n;
    if (op == OP_DRAW) begin
      gen_word = xorshift_next(gen_word);
      if (keep) begin
        owed_results.push_back('{value: gen_word, last: 1'b1});
      end
    end else begin
      n = (req_len > MAX_FILL) ? int'(MAX_FILL) : int'(req_len);
      gen_word = xorshift_next(gen_word);
      mode = gen_word[MODE_W-1:0];
      for (int i = 0; i < n; i++) begin
        case (mode)
          MODE_ZERO:  b = '0;
          MODE_ONES:  b = '1;
          MODE_INDEX: b = i[BYTE_W-1:0];
          MODE_COUNT: b = 8'(n - i);
          MODE_PICK: begin
            gen_word = xorshift_next(gen_word);
            b = PICK_LUT[gen_word[3:0]];
          end
          default: begin
            gen_word = xorshift_next(gen_word);
            b = gen_word[BYTE_W-1:0];
          end
        endcase
        if (keep) begin
          owed_results.push_back('{value: {24'b0, b}, last: (i == n - 1)});
        end
      end
    end
  endtask

  function automatic void flag_mismatch(input string what, input logic [WORD_W-1:0] want,
                                        input logic [WORD_W-1:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected %h, got %h", what, want, got);
    end
  endfunction

  // Present one transaction, starting at a falling edge; returns at a falling edge
  task automatic send_item(input logic op, input logic [LEN_W-1:0] len,
                           input bit typed, input logic [WORD_W-1:0] arg);
    int n;
    while (!quiet_stretch && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    fill_length <= len;
    do @(posedge clk); while (!in_ready);
    if (!typed) begin
      forecast_run(op, len, 1'b1);
    end else begin
      forecast_run(op, len, 1'b0);
      if (op == OP_DRAW) begin
        owed_results.push_back('{value: arg, last: 1'b1});
      end else begin
        n = (len > MAX_FILL) ? int'(MAX_FILL) : int'(len);
        for (int i = 0; i < n; i++) begin
          owed_results.push_back('{value: {24'b0, arg[BYTE_W-1:0]}, last: (i == n - 1)});
        end
      end
    end
    @(negedge clk);
  endtask

  // Hold off the sender until every result is in and the unit has gone quiet
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (owed_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Seed write; only called while the unit is idle
  task automatic write_seed(input logic [WORD_W-1:0] s);
    cfg_we    <= 1'b1;
    cfg_wdata <= s;
    @(negedge clk);
    cfg_we   <= 1'b0;
    gen_word = (s == '0) ? SEED_DEFAULT : s;
  endtask

  // Output side backpressure
  always @(negedge clk) begin
    out_ready <= quiet_stretch || ($urandom_range(99) >= 13);
  end

  // Compare each result with the oldest outstanding expectation
  always @(posedge clk) begin : result_check
    fill_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (owed_results.size() == 0) begin
        flag_mismatch("result with nothing pending", '0, value);
      end else begin
        want = owed_results.pop_front();
        if (value !== want.value) begin
          flag_mismatch("value", want.value, value);
        end
        if (last !== want.last) begin
          flag_mismatch("last", {31'b0, want.last}, {31'b0, last});
        end
      end
    end
  end

  // Watchdog: cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("xorshift_pattern_filler_unit: mismatch");
    $finish;
  end

  initial begin : stimulus
    logic             op;
    logic [LEN_W-1:0] len;
    int               pick;
    plan = '{
      '{ROW_ITEM,  OP_DRAW, 7'd0,   32'd0},
      '{ROW_ITEM,  OP_FILL, 7'd0,   32'd0},
      '{ROW_ITEM,  OP_FILL, 7'd1,   32'd0},
      '{ROW_ITEM,  OP_FILL, 7'd64,  32'd0},
      '{ROW_ITEM,  OP_FILL, 7'd65,  32'd0},
      '{ROW_ITEM,  OP_FILL, 7'd127, 32'd0},
      '{ROW_ITEM,  OP_DRAW, 7'd127, 32'd0},
      // seed 1: first word is 0x00042021, the next one selects the all-ones mode
      '{ROW_SEED,  OP_DRAW, 7'd0,   32'h0000_0001},
      '{ROW_TYPED, OP_DRAW, 7'd0,   32'h0004_2021},
      '{ROW_TYPED, OP_FILL, 7'd3,   32'h0000_00ff},
      '{ROW_ITEM,  OP_FILL, 7'd0,   32'd0},
      // zero seed falls back to the default
      '{ROW_SEED,  OP_DRAW, 7'd0,   32'h0000_0000},
      '{ROW_ITEM,  OP_DRAW, 7'd0,   32'd0},
      '{ROW_ITEM,  OP_FILL, 7'd64,  32'd0},
      '{ROW_SEED,  OP_DRAW, 7'd0,   32'hffff_ffff},
      '{ROW_ITEM,  OP_DRAW, 7'd0,   32'd0},
      '{ROW_ITEM,  OP_FILL, 7'd10,  32'd0},
      '{ROW_ITEM,  OP_FILL, 7'd2,   32'd0},
      '{ROW_ITEM,  OP_FILL, 7'd7,   32'd0},
      '{ROW_ITEM,  OP_FILL, 7'd33,  32'd0},
      '{ROW_ITEM,  OP_DRAW, 7'd85,  32'd0},
      '{ROW_ITEM,  OP_FILL, 7'd42,  32'd0}
    };

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table
    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (plan[r].kind == ROW_SEED) begin
        drain_and_settle();
        write_seed(plan[r].arg);
      end else begin
        send_item(plan[r].op, plan[r].len, plan[r].kind == ROW_TYPED, plan[r].arg);
      end
    end

    // Random phases, each under a fresh seed
    for (int ph = 0; ph < 3; ph++) begin
      drain_and_settle();
      write_seed($urandom);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        quiet_stretch = (ph == 1) && (k < 30);
        // in the first phase, the sender holds off mid-phase until the unit has drained
        if (ph == 0 && k == PHASE_ITEMS / 2) begin
          drain_and_settle();
        end
        op = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 60) begin
          len = 7'($urandom_range(0, 12));
        end else if (pick < 85) begin
          len = 7'($urandom_range(13, 64));
        end else if (pick < 95) begin
          len = 7'($urandom_range(65, 127));
        end else begin
          len = MAX_FILL;
        end
        send_item(op, len, 1'b0, '0);
      end
    end
    quiet_stretch = 1'b0;

    drain_and_settle();
    if (owed_results.size() != 0) begin
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("xorshift_pattern_filler_unit: match");
    end else begin
      $display("xorshift_pattern_filler_unit: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/xpf_pkg.sv
rtl/xpf_datapath.sv
rtl/xpf_ctrl.sv
rtl/xorshift_pattern_filler_unit.sv
tb/testbench.sv
